// ===== rtl/core/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_pkg: shared definitions of the peak-to-peak current meter
// Field widths, arithmetic constants, register indexes, the controller state
// encoding and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

  // Field widths.
  localparam int ADC_W       = 12;
  localparam int MV_W        = 12;
  localparam int MIN_W       = 13;
  localparam int CURRENT_W   = 14;
  localparam int POWER_W     = 12;
  localparam int SENS_W      = 10;
  localparam int NOISE_W     = 14;
  localparam int MAINS_W     = 9;
  localparam int GROUP_W     = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;

  // Internal arithmetic widths.
  localparam int SCALE_PROD_W = 24;  // raw * 3300
  localparam int SPREAD_W     = 22;  // (peak - trough) * 707
  localparam int CUR_SUM_W    = 17;  // up to eight window currents
  localparam int POWER_PROD_W = 23;  // filtered current * mains volts

  // Arithmetic constants.
  localparam int MV_FULL_SCALE = 3300;
  localparam int ADC_MAX       = 4095;
  localparam int MIN_RESET_MV  = 5000;
  localparam int RMS_NUM       = 707;
  localparam int CURRENT_LIMIT = 16000;
  localparam int POWER_LIMIT   = 4095;
  localparam int MILLI         = 1000;
  localparam int MAX_GROUP     = 8;

  // Division by 1000 as a multiply by ceil(2^33 / 1000) and a shift; the
  // result is exact for every product below 2^23.
  localparam int MILLI_RECIP_W = 24;
  localparam int MILLI_RECIP   = 8589935;
  localparam int MILLI_SHIFT   = 33;

  // Defaults.
  localparam int MAX_WINDOW_SAMPLES_DEF = 128;
  localparam int SENS_RESET             = 185;
  localparam int NOISE_RESET            = 250;
  localparam int MAINS_RESET            = 220;
  localparam int GROUP_RESET            = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SENSITIVITY = 3'd0,
    CFG_NOISE_FLOOR = 3'd1,
    CFG_MAINS_VOLTS = 3'd2,
    CFG_GROUP_SIZE  = 3'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    DIV_MEAN_RAW,
    DIV_MEAN_MV,
    DIV_CURRENT,
    DIV_FILTER
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_ACCUM,
    S_RAW_GO,
    S_RAW_WAIT,
    S_MV_GO,
    S_MV_WAIT,
    S_CUR_GO,
    S_CUR_WAIT,
    S_FILT_GO,
    S_FILT_WAIT,
    S_PWR_MUL,
    S_PWR_RECIP,
    S_PWR_SAT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic     load;         // capture the accepted request
    logic     scale;        // register raw * 3300
    logic     accum;        // update peak, trough, sums and count
    logic     spread;       // register (peak - trough) * 707
    logic     div_start;
    logic     div_capture;  // take the quotient when the divider finishes
    div_sel_t div_sel;
    logic     power_mul;    // register filtered current * mains volts
    logic     power_recip;  // register that product scaled down by 1000
    logic     power_sat;    // limit the scaled product into the power register
    logic     emit;         // load the result register and clear the window
  } ptp_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic group_done;
    logic power_needed;
    logic out_free;
  } ptp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptp_divider.sv =====
// ----------------------------------------------------------------------------
// ptp_divider: restoring divider, one quotient bit per cycle
// Loads dividend and divisor on start, pulses done when the quotient is final.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_divider #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic      [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [DEN_W:0]    rem_shift;
  logic [DEN_W:0]    trial;

  assign rem_shift = {rem, quotient[NUM_W-1]};
  assign trial     = rem_shift - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (busy) begin
      // A clear sign bit means the shifted remainder covers the divisor.
      if (!trial[DEN_W]) begin
        rem      <= trial[DEN_W-1:0];
        quotient <= {quotient[NUM_W-2:0], 1'b1};
      end else begin
        rem      <= rem_shift[DEN_W-1:0];
        quotient <= {quotient[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptp_datapath.sv =====
// ----------------------------------------------------------------------------
// ptp_datapath: window accumulators, configuration and result register
// Converts samples to millivolts, keeps the window and group state, feeds the
// shared divider and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_datapath #(
  parameter int MAX_WINDOW_SAMPLES = ptp_pkg::MAX_WINDOW_SAMPLES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ptp_pkg::ptp_cmd_t                  cmd,
  output ptp_pkg::ptp_status_t                    status,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ptp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [ptp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [ptp_pkg::ADC_W-1:0]          adc_sample,
  input  wire logic                               window_end,
  input  wire logic                               relay_on,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [ptp_pkg::ADC_W-1:0]               mean_raw,
  output logic [ptp_pkg::MV_W-1:0]                mean_millivolts,
  output logic [ptp_pkg::MV_W-1:0]                peak_millivolts,
  output logic [ptp_pkg::MV_W-1:0]                trough_millivolts,
  output logic [ptp_pkg::CURRENT_W-1:0]           window_current_ma,
  output logic                                    average_ready,
  output logic [ptp_pkg::CURRENT_W-1:0]           filtered_current_ma,
  output logic [ptp_pkg::POWER_W-1:0]             power_watts
);

  localparam int CNT_W = $clog2(MAX_WINDOW_SAMPLES + 1);
  localparam int SUM_W = $clog2(MAX_WINDOW_SAMPLES * ptp_pkg::ADC_MAX + 1);
  localparam int DEN_W = (CNT_W > ptp_pkg::SENS_W + 1) ? CNT_W : ptp_pkg::SENS_W + 1;
  localparam int NUM_W = (SUM_W > ptp_pkg::SPREAD_W) ? SUM_W : ptp_pkg::SPREAD_W;
  localparam int RECIP_PROD_W = ptp_pkg::POWER_PROD_W + ptp_pkg::MILLI_RECIP_W;
  localparam int POWER_Q_W    = RECIP_PROD_W - ptp_pkg::MILLI_SHIFT;

  // Configuration registers.
  logic [ptp_pkg::SENS_W-1:0]  sensitivity;
  logic [ptp_pkg::NOISE_W-1:0] noise_floor;
  logic [ptp_pkg::MAINS_W-1:0] mains_volts;
  logic [ptp_pkg::GROUP_W-1:0] group_size;

  // Window and group state.
  logic [ptp_pkg::MV_W-1:0]      running_max;
  logic [ptp_pkg::MIN_W-1:0]     running_min;
  logic [SUM_W-1:0]              raw_sum;
  logic [SUM_W-1:0]              mv_sum;
  logic [CNT_W-1:0]              sample_count;
  logic [ptp_pkg::GROUP_W-1:0]   window_count;
  logic [ptp_pkg::CUR_SUM_W-1:0] current_sum;

  // Working registers.
  logic [ptp_pkg::ADC_W-1:0]        raw;
  logic                             last;
  logic                             relay;
  logic [ptp_pkg::SCALE_PROD_W-1:0] scale_prod;
  logic [ptp_pkg::SPREAD_W-1:0]     spread;
  logic [ptp_pkg::POWER_PROD_W-1:0] power_prod;
  logic [POWER_Q_W-1:0]             power_quo;
  logic [ptp_pkg::ADC_W-1:0]        mean_raw_r;
  logic [ptp_pkg::MV_W-1:0]         mean_mv_r;
  logic [ptp_pkg::CURRENT_W-1:0]    current_r;
  logic [ptp_pkg::CURRENT_W-1:0]    filtered_r;
  logic [ptp_pkg::POWER_W-1:0]      power_r;

  logic [ptp_pkg::MV_W-1:0]      scale_q;
  logic [ptp_pkg::MIN_W-1:0]     scale_r;
  logic [ptp_pkg::MV_W-1:0]      mv;
  logic [ptp_pkg::SENS_W-1:0]    sens_eff;
  logic [ptp_pkg::GROUP_W-1:0]   group_eff;
  logic                          group_done;
  logic [NUM_W-1:0]              div_num;
  logic [DEN_W-1:0]              div_den;
  logic                          div_done;
  logic [NUM_W-1:0]              div_quo;
  logic [RECIP_PROD_W-1:0]       recip_prod;
  logic [ptp_pkg::CURRENT_W-1:0] current_value;
  logic [ptp_pkg::CURRENT_W-1:0] filtered_value;
  logic [ptp_pkg::POWER_W-1:0]   power_value;

  assign cfg_ready = 1'b1;

  // raw * 3300 / 4095: the quotient by 4096 is low by at most one, and the
  // remainder against 4095 is the low twelve bits plus that quotient.
  assign scale_q = scale_prod[ptp_pkg::SCALE_PROD_W-1:12];
  assign scale_r = ptp_pkg::MIN_W'(scale_prod[11:0]) + ptp_pkg::MIN_W'(scale_q);
  assign mv      = scale_q + ptp_pkg::MV_W'(scale_r >= ptp_pkg::MIN_W'(ptp_pkg::ADC_MAX));

  assign sens_eff   = (sensitivity == '0) ? ptp_pkg::SENS_W'(1) : sensitivity;
  assign group_eff  = (group_size == '0) ? ptp_pkg::GROUP_W'(1) :
                      (group_size > ptp_pkg::GROUP_W'(ptp_pkg::MAX_GROUP)) ?
                      ptp_pkg::GROUP_W'(ptp_pkg::MAX_GROUP) : group_size;
  assign group_done = (window_count >= group_eff);

  assign recip_prod = RECIP_PROD_W'(power_prod) * RECIP_PROD_W'(ptp_pkg::MILLI_RECIP);

  always_comb begin
    case (cmd.div_sel)
      ptp_pkg::DIV_MEAN_RAW: begin
        div_num = NUM_W'(raw_sum);
        div_den = DEN_W'(sample_count);
      end
      ptp_pkg::DIV_MEAN_MV: begin
        div_num = NUM_W'(mv_sum);
        div_den = DEN_W'(sample_count);
      end
      ptp_pkg::DIV_CURRENT: begin
        div_num = NUM_W'(spread);
        div_den = DEN_W'({sens_eff, 1'b0});
      end
      ptp_pkg::DIV_FILTER: begin
        div_num = NUM_W'(current_sum);
        div_den = DEN_W'(window_count);
      end
      default: begin
        div_num = '0;
        div_den = DEN_W'(1);
      end
    endcase
  end

  ptp_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // The noise floor is checked before the estimate is limited.
  always_comb begin
    if (div_quo < NUM_W'(noise_floor)) begin
      current_value = '0;
    end else if (div_quo > NUM_W'(ptp_pkg::CURRENT_LIMIT)) begin
      current_value = ptp_pkg::CURRENT_W'(ptp_pkg::CURRENT_LIMIT);
    end else begin
      current_value = div_quo[ptp_pkg::CURRENT_W-1:0];
    end
    if (div_quo > NUM_W'(ptp_pkg::CURRENT_LIMIT)) begin
      filtered_value = ptp_pkg::CURRENT_W'(ptp_pkg::CURRENT_LIMIT);
    end else begin
      filtered_value = div_quo[ptp_pkg::CURRENT_W-1:0];
    end
    if (power_quo > POWER_Q_W'(ptp_pkg::POWER_LIMIT)) begin
      power_value = ptp_pkg::POWER_W'(ptp_pkg::POWER_LIMIT);
    end else begin
      power_value = power_quo[ptp_pkg::POWER_W-1:0];
    end
  end

  always_comb begin
    status.last         = last;
    status.div_done     = div_done;
    status.group_done   = group_done;
    status.power_needed = relay && (filtered_r != '0);
    status.out_free     = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity  <= ptp_pkg::SENS_W'(ptp_pkg::SENS_RESET);
      noise_floor  <= ptp_pkg::NOISE_W'(ptp_pkg::NOISE_RESET);
      mains_volts  <= ptp_pkg::MAINS_W'(ptp_pkg::MAINS_RESET);
      group_size   <= ptp_pkg::GROUP_W'(ptp_pkg::GROUP_RESET);
      running_max  <= '0;
      running_min  <= ptp_pkg::MIN_W'(ptp_pkg::MIN_RESET_MV);
      raw_sum      <= '0;
      mv_sum       <= '0;
      sample_count <= '0;
      window_count <= '0;
      current_sum  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          ptp_pkg::CFG_SENSITIVITY: sensitivity <= cfg_data[ptp_pkg::SENS_W-1:0];
          ptp_pkg::CFG_NOISE_FLOOR: noise_floor <= cfg_data[ptp_pkg::NOISE_W-1:0];
          ptp_pkg::CFG_MAINS_VOLTS: mains_volts <= cfg_data[ptp_pkg::MAINS_W-1:0];
          ptp_pkg::CFG_GROUP_SIZE:  group_size  <= cfg_data[ptp_pkg::GROUP_W-1:0];
          default: ;
        endcase
      end

      if (cmd.accum) begin
        if (mv > running_max) begin
          running_max <= mv;
        end
        if (ptp_pkg::MIN_W'(mv) < running_min) begin
          running_min <= ptp_pkg::MIN_W'(mv);
        end
        // A full window still tracks peak and trough but stops summing.
        if (sample_count < CNT_W'(MAX_WINDOW_SAMPLES)) begin
          raw_sum      <= raw_sum + SUM_W'(raw);
          mv_sum       <= mv_sum + SUM_W'(mv);
          sample_count <= sample_count + 1'b1;
        end
      end

      if (cmd.div_capture && div_done && cmd.div_sel == ptp_pkg::DIV_CURRENT) begin
        current_sum  <= current_sum + ptp_pkg::CUR_SUM_W'(current_value);
        window_count <= window_count + 1'b1;
      end

      if (cmd.emit) begin
        running_max  <= '0;
        running_min  <= ptp_pkg::MIN_W'(ptp_pkg::MIN_RESET_MV);
        raw_sum      <= '0;
        mv_sum       <= '0;
        sample_count <= '0;
        if (group_done) begin
          current_sum  <= '0;
          window_count <= '0;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw   <= adc_sample;
      last  <= window_end;
      relay <= relay_on;
    end
    if (cmd.scale) begin
      scale_prod <= ptp_pkg::SCALE_PROD_W'(raw) *
                    ptp_pkg::SCALE_PROD_W'(ptp_pkg::MV_FULL_SCALE);
    end
    if (cmd.spread) begin
      spread <= ptp_pkg::SPREAD_W'(running_max - running_min[ptp_pkg::MV_W-1:0]) *
                ptp_pkg::SPREAD_W'(ptp_pkg::RMS_NUM);
    end
    if (cmd.power_mul) begin
      power_prod <= ptp_pkg::POWER_PROD_W'(filtered_r) *
                    ptp_pkg::POWER_PROD_W'(mains_volts);
    end
    if (cmd.power_recip) begin
      power_quo <= recip_prod[RECIP_PROD_W-1:ptp_pkg::MILLI_SHIFT];
    end
    if (cmd.power_sat) begin
      power_r <= power_value;
    end
    if (cmd.div_capture && div_done) begin
      case (cmd.div_sel)
        ptp_pkg::DIV_MEAN_RAW: mean_raw_r <= div_quo[ptp_pkg::ADC_W-1:0];
        ptp_pkg::DIV_MEAN_MV:  mean_mv_r  <= div_quo[ptp_pkg::MV_W-1:0];
        ptp_pkg::DIV_CURRENT: begin
          current_r  <= current_value;
          filtered_r <= '0;
          power_r    <= '0;
        end
        ptp_pkg::DIV_FILTER:   filtered_r <= filtered_value;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      mean_raw            <= mean_raw_r;
      mean_millivolts     <= mean_mv_r;
      peak_millivolts     <= running_max;
      trough_millivolts   <= running_min[ptp_pkg::MV_W-1:0];
      window_current_ma   <= current_r;
      average_ready       <= group_done;
      filtered_current_ma <= filtered_r;
      power_watts         <= power_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptp_controller.sv =====
// ----------------------------------------------------------------------------
// ptp_controller: sequencer of the peak-to-peak current meter
// Steps each request through conversion and accumulation, and at a window end
// through the divisions, the power product and the hand-off to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ptp_pkg::ptp_status_t status,
  output ptp_pkg::ptp_cmd_t         cmd
);

  ptp_pkg::state_t state;
  ptp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ptp_pkg::S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = ptp_pkg::DIV_MEAN_RAW;
    unique case (state)
      ptp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ptp_pkg::S_SCALE;
        end
      end
      ptp_pkg::S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ptp_pkg::S_ACCUM;
      end
      ptp_pkg::S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = status.last ? ptp_pkg::S_RAW_GO : ptp_pkg::S_IDLE;
      end
      ptp_pkg::S_RAW_GO: begin
        cmd.spread    = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = ptp_pkg::S_RAW_WAIT;
      end
      ptp_pkg::S_RAW_WAIT: begin
        cmd.div_capture = 1'b1;
        if (status.div_done) begin
          state_next = ptp_pkg::S_MV_GO;
        end
      end
      ptp_pkg::S_MV_GO: begin
        cmd.div_sel   = ptp_pkg::DIV_MEAN_MV;
        cmd.div_start = 1'b1;
        state_next    = ptp_pkg::S_MV_WAIT;
      end
      ptp_pkg::S_MV_WAIT: begin
        cmd.div_sel     = ptp_pkg::DIV_MEAN_MV;
        cmd.div_capture = 1'b1;
        if (status.div_done) begin
          state_next = ptp_pkg::S_CUR_GO;
        end
      end
      ptp_pkg::S_CUR_GO: begin
        cmd.div_sel   = ptp_pkg::DIV_CURRENT;
        cmd.div_start = 1'b1;
        state_next    = ptp_pkg::S_CUR_WAIT;
      end
      ptp_pkg::S_CUR_WAIT: begin
        cmd.div_sel     = ptp_pkg::DIV_CURRENT;
        cmd.div_capture = 1'b1;
        if (status.div_done) begin
          state_next = ptp_pkg::S_FILT_GO;
        end
      end
      ptp_pkg::S_FILT_GO: begin
        // The group counters already include this window here.
        cmd.div_sel = ptp_pkg::DIV_FILTER;
        if (status.group_done) begin
          cmd.div_start = 1'b1;
          state_next    = ptp_pkg::S_FILT_WAIT;
        end else begin
          state_next = ptp_pkg::S_EMIT;
        end
      end
      ptp_pkg::S_FILT_WAIT: begin
        cmd.div_sel     = ptp_pkg::DIV_FILTER;
        cmd.div_capture = 1'b1;
        if (status.div_done) begin
          state_next = ptp_pkg::S_PWR_MUL;
        end
      end
      ptp_pkg::S_PWR_MUL: begin
        if (status.power_needed) begin
          cmd.power_mul = 1'b1;
          state_next    = ptp_pkg::S_PWR_RECIP;
        end else begin
          state_next = ptp_pkg::S_EMIT;
        end
      end
      ptp_pkg::S_PWR_RECIP: begin
        cmd.power_recip = 1'b1;
        state_next      = ptp_pkg::S_PWR_SAT;
      end
      ptp_pkg::S_PWR_SAT: begin
        cmd.power_sat = 1'b1;
        state_next    = ptp_pkg::S_EMIT;
      end
      ptp_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ptp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/peak_to_peak_current_meter.sv =====
// ----------------------------------------------------------------------------
// peak_to_peak_current_meter: windowed peak-to-peak current estimator
// Converts sensor samples to millivolts, tracks each window and reports means,
// extremes, an RMS current estimate and, per group of windows, a filtered current and power.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   adc_sample, window_end, relay_on
//   out       source     out_valid / out_stall mean_raw .. power_watts
//   cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample that does not end a window passes through conversion and
// accumulation in turn before the next request can be accepted.
// A window-end sample adds up to four passes of the shared bit-serial divider,
// whose dividend is D bits wide (22 at the default size), then the power product
// and its scaling when power is needed, and the hand-off, each in a state of its own.
// Reset is synchronous; it restores the register defaults and clears the
// window and group state. The result register holds one result while
// out_stall is high; a second window end waits for it in its last state.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_to_peak_current_meter #(
  parameter int MAX_WINDOW_SAMPLES = ptp_pkg::MAX_WINDOW_SAMPLES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ptp_pkg::ADC_W-1:0]       adc_sample,
  input  wire logic                            window_end,
  input  wire logic                            relay_on,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [ptp_pkg::ADC_W-1:0]            mean_raw,
  output logic [ptp_pkg::MV_W-1:0]             mean_millivolts,
  output logic [ptp_pkg::MV_W-1:0]             peak_millivolts,
  output logic [ptp_pkg::MV_W-1:0]             trough_millivolts,
  output logic [ptp_pkg::CURRENT_W-1:0]        window_current_ma,
  output logic                                 average_ready,
  output logic [ptp_pkg::CURRENT_W-1:0]        filtered_current_ma,
  output logic [ptp_pkg::POWER_W-1:0]          power_watts,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ptp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ptp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ptp_pkg::ptp_cmd_t    cmd;
  ptp_pkg::ptp_status_t status;

  ptp_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ptp_datapath #(
    .MAX_WINDOW_SAMPLES (MAX_WINDOW_SAMPLES)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .adc_sample          (adc_sample),
    .window_end          (window_end),
    .relay_on            (relay_on),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .mean_raw            (mean_raw),
    .mean_millivolts     (mean_millivolts),
    .peak_millivolts     (peak_millivolts),
    .trough_millivolts   (trough_millivolts),
    .window_current_ma   (window_current_ma),
    .average_ready       (average_ready),
    .filtered_current_ma (filtered_current_ma),
    .power_watts         (power_watts)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ptp_checker.sv =====
// ----------------------------------------------------------------------------
// ptp_checker: port-level checks of the peak-to-peak current meter
// Watches the top-level ports over time and reports violations.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [ptp_pkg::ADC_W-1:0]       mean_raw,
  input wire logic [ptp_pkg::MV_W-1:0]        peak_millivolts,
  input wire logic [ptp_pkg::MV_W-1:0]        trough_millivolts,
  input wire logic [ptp_pkg::CURRENT_W-1:0]   window_current_ma,
  input wire logic                            average_ready,
  input wire logic [ptp_pkg::CURRENT_W-1:0]   filtered_current_ma,
  input wire logic [ptp_pkg::POWER_W-1:0]     power_watts
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean_raw) &&
      $stable(window_current_ma) && $stable(power_watts))
    else $error("stalled result changed");

  // An accepted request leaves the input side busy in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted on consecutive cycles");

  // A result never appears in the cycle right after a request is accepted.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result raised right after a request");

  // Group figures are zero unless the window completes a group.
  a_group_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !average_ready |-> filtered_current_ma == '0 && power_watts == '0)
    else $error("group figures set outside a completed group");

  // The trough never lies above the peak, and the peak stays in range.
  a_extremes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> trough_millivolts <= peak_millivolts &&
      peak_millivolts <= ptp_pkg::MV_W'(ptp_pkg::MV_FULL_SCALE))
    else $error("window extremes out of order or range");

endmodule

bind peak_to_peak_current_meter ptp_checker u_ptp_checker (.*);

`default_nettype wire
